// ===== rtl/cbbf_pkg.sv =====
// shared types and constants of the content bounding box finder
package cbbf_pkg;

    // item kinds on the input channel
    localparam logic [1:0] KIND_PIXEL    = 2'd0;
    localparam logic [1:0] KIND_PAGE_END = 2'd1;
    localparam logic [1:0] KIND_REPORT   = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_WINDOW_LEFT   = 3'd0;
    localparam logic [2:0] CFG_WINDOW_TOP    = 3'd1;
    localparam logic [2:0] CFG_WINDOW_RIGHT  = 3'd2;
    localparam logic [2:0] CFG_WINDOW_BOTTOM = 3'd3;
    localparam logic [2:0] CFG_ALPHA_FLOOR   = 3'd4;
    localparam logic [2:0] CFG_WHITE_LEVEL   = 3'd5;
    localparam logic [2:0] CFG_PAD_PIXELS    = 3'd6;

    // reset values of the configuration registers
    localparam logic [12:0] RST_WINDOW_LEFT   = 13'd0;
    localparam logic [12:0] RST_WINDOW_TOP    = 13'd0;
    localparam logic [12:0] RST_WINDOW_RIGHT  = 13'd4096;
    localparam logic [12:0] RST_WINDOW_BOTTOM = 13'd4096;
    localparam logic [7:0]  RST_ALPHA_FLOOR   = 8'd16;
    localparam logic [7:0]  RST_WHITE_LEVEL   = 8'd245;
    localparam logic [12:0] RST_PAD_PIXELS    = 13'd0;

    // input item
    typedef struct packed {
        logic [1:0]  kind;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
    } t_item;

    // result item
    typedef struct packed {
        logic        found;
        logic [12:0] box_left;
        logic [12:0] box_top;
        logic [12:0] box_right;
        logic [12:0] box_bottom;
    } t_result;

    // settings seen by front and back, window already clipped to the frame
    typedef struct packed {
        logic [12:0] win_left;
        logic [12:0] win_top;
        logic [12:0] win_right;
        logic [12:0] win_bottom;
        logic [7:0]  alpha_floor;
        logic [7:0]  white_level;
        logic [12:0] pad;
    } t_cfg;

    // operations handed from front to back
    typedef enum logic [1:0] {
        OP_PIXEL,
        OP_PAGE_END,
        OP_REPORT
    } t_op;

    // classified command in the queue
    typedef struct packed {
        t_op         op;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
    } t_cmd;

endpackage

// ===== rtl/cbbf_front.sv =====
// front end: takes items, classifies pixels and queues the work that matters
module cbbf_front
    import cbbf_pkg::*;
(
    input  logic  i_valid,
    input  t_item i_item,
    input  t_cfg  i_cfg,
    input  logic  i_full,
    output logic  o_stall,
    output logic  o_push,
    output t_cmd  o_cmd
);

    logic in_window;
    logic opaque;
    logic white;
    logic content;
    logic useful;

    // pixel classification against window, alpha floor and white level
    always_comb begin
        in_window = ({1'b0, i_item.pos_x} >= i_cfg.win_left)
                 && ({1'b0, i_item.pos_x} <  i_cfg.win_right)
                 && ({1'b0, i_item.pos_y} >= i_cfg.win_top)
                 && ({1'b0, i_item.pos_y} <  i_cfg.win_bottom);
        opaque  = i_item.alpha >= i_cfg.alpha_floor;
        white   = (i_item.red   >= i_cfg.white_level)
               && (i_item.green >= i_cfg.white_level)
               && (i_item.blue  >= i_cfg.white_level);
        content = in_window && opaque && !white;
    end

    // decide what goes to the back end; background pixels and unused kinds are dropped
    always_comb begin
        useful      = 1'b0;
        o_cmd.op    = OP_PIXEL;
        o_cmd.pos_x = i_item.pos_x;
        o_cmd.pos_y = i_item.pos_y;
        unique case (i_item.kind)
            KIND_PIXEL: begin
                useful   = content;
                o_cmd.op = OP_PIXEL;
            end
            KIND_PAGE_END: begin
                useful   = 1'b1;
                o_cmd.op = OP_PAGE_END;
            end
            KIND_REPORT: begin
                useful   = 1'b1;
                o_cmd.op = OP_REPORT;
            end
            default: begin
                useful   = 1'b0;
                o_cmd.op = OP_PIXEL;
            end
        endcase
    end

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full && useful;

endmodule

// ===== rtl/cbbf_queue.sv =====
// short command queue between front and back
module cbbf_queue
    import cbbf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty,
    output logic o_full
);

    localparam int Depth = 4;

    t_cmd       r_mem [Depth];
    logic [1:0] r_wr_ptr;
    logic [1:0] r_rd_ptr;
    logic [2:0] r_count;
    logic [1:0] n_wr_ptr;
    logic [1:0] n_rd_ptr;
    logic [2:0] n_count;
    logic       do_push;
    logic       do_pop;

    assign o_empty = (r_count == 3'd0);
    assign o_full  = (r_count == 3'(Depth));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 2'd1 : r_wr_ptr;
        n_rd_ptr = do_pop  ? r_rd_ptr + 2'd1 : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 3'd1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== rtl/cbbf_back.sv =====
// back end: page extent, padded union box and the result register
module cbbf_back
    import cbbf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_empty,
    input  t_cmd    i_cmd,
    output logic    o_pop,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_result
);

    // page extent
    logic        r_page_has;
    logic [11:0] r_min_x;
    logic [11:0] r_min_y;
    logic [11:0] r_max_x;
    logic [11:0] r_max_y;
    logic        n_page_has;
    logic [11:0] n_min_x;
    logic [11:0] n_min_y;
    logic [11:0] n_max_x;
    logic [11:0] n_max_y;

    // running box
    logic        r_union_valid;
    logic [12:0] r_union_left;
    logic [12:0] r_union_top;
    logic [12:0] r_union_right;
    logic [12:0] r_union_bottom;
    logic        n_union_valid;
    logic [12:0] n_union_left;
    logic [12:0] n_union_top;
    logic [12:0] n_union_right;
    logic [12:0] n_union_bottom;

    // result register
    logic        r_out_valid;
    t_result     r_out;
    logic        n_out_valid;
    t_result     n_out;

    logic        out_free;
    logic        exec;

    // padded page box
    logic [13:0] low_x_lim;
    logic [13:0] low_y_lim;
    logic [13:0] high_x_sum;
    logic [13:0] high_y_sum;
    logic [12:0] pad_left;
    logic [12:0] pad_top;
    logic [12:0] pad_right;
    logic [12:0] pad_bottom;

    assign out_free = !r_out_valid || !i_stall;
    assign o_pop    = !i_empty && ((i_cmd.op != OP_REPORT) || out_free);
    assign exec     = o_pop;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // grow the page extent by the padding and clip at the window edges
    always_comb begin
        low_x_lim  = {1'b0, i_cfg.win_left} + {1'b0, i_cfg.pad};
        low_y_lim  = {1'b0, i_cfg.win_top}  + {1'b0, i_cfg.pad};
        high_x_sum = {2'b0, r_max_x} + 14'd1 + {1'b0, i_cfg.pad};
        high_y_sum = {2'b0, r_max_y} + 14'd1 + {1'b0, i_cfg.pad};
        pad_left   = ({2'b0, r_min_x} >= low_x_lim)
                   ? {1'b0, r_min_x} - i_cfg.pad : i_cfg.win_left;
        pad_top    = ({2'b0, r_min_y} >= low_y_lim)
                   ? {1'b0, r_min_y} - i_cfg.pad : i_cfg.win_top;
        pad_right  = (high_x_sum > {1'b0, i_cfg.win_right})
                   ? i_cfg.win_right : high_x_sum[12:0];
        pad_bottom = (high_y_sum > {1'b0, i_cfg.win_bottom})
                   ? i_cfg.win_bottom : high_y_sum[12:0];
    end

    // execute one command
    always_comb begin
        n_page_has     = r_page_has;
        n_min_x        = r_min_x;
        n_min_y        = r_min_y;
        n_max_x        = r_max_x;
        n_max_y        = r_max_y;
        n_union_valid  = r_union_valid;
        n_union_left   = r_union_left;
        n_union_top    = r_union_top;
        n_union_right  = r_union_right;
        n_union_bottom = r_union_bottom;
        n_out_valid    = r_out_valid && i_stall;
        n_out          = r_out;
        if (exec) begin
            unique case (i_cmd.op)
                OP_PIXEL: begin
                    n_page_has = 1'b1;
                    if (!r_page_has) begin
                        n_min_x = i_cmd.pos_x;
                        n_max_x = i_cmd.pos_x;
                        n_min_y = i_cmd.pos_y;
                        n_max_y = i_cmd.pos_y;
                    end else begin
                        if (i_cmd.pos_x < r_min_x) n_min_x = i_cmd.pos_x;
                        if (i_cmd.pos_x > r_max_x) n_max_x = i_cmd.pos_x;
                        if (i_cmd.pos_y < r_min_y) n_min_y = i_cmd.pos_y;
                        if (i_cmd.pos_y > r_max_y) n_max_y = i_cmd.pos_y;
                    end
                end
                OP_PAGE_END: begin
                    if (r_page_has) begin
                        n_union_valid = 1'b1;
                        if (!r_union_valid) begin
                            n_union_left   = pad_left;
                            n_union_top    = pad_top;
                            n_union_right  = pad_right;
                            n_union_bottom = pad_bottom;
                        end else begin
                            if (pad_left < r_union_left)     n_union_left   = pad_left;
                            if (pad_top < r_union_top)       n_union_top    = pad_top;
                            if (pad_right > r_union_right)   n_union_right  = pad_right;
                            if (pad_bottom > r_union_bottom) n_union_bottom = pad_bottom;
                        end
                    end
                    n_page_has = 1'b0;
                    n_min_x    = '0;
                    n_min_y    = '0;
                    n_max_x    = '0;
                    n_max_y    = '0;
                end
                OP_REPORT: begin
                    n_out_valid = 1'b1;
                    n_out.found = r_union_valid;
                    if (r_union_valid) begin
                        n_out.box_left   = r_union_left;
                        n_out.box_top    = r_union_top;
                        n_out.box_right  = r_union_right;
                        n_out.box_bottom = r_union_bottom;
                    end else begin
                        n_out.box_left   = i_cfg.win_left;
                        n_out.box_top    = i_cfg.win_top;
                        n_out.box_right  = i_cfg.win_right;
                        n_out.box_bottom = i_cfg.win_bottom;
                    end
                    n_union_valid  = 1'b0;
                    n_union_left   = '0;
                    n_union_top    = '0;
                    n_union_right  = '0;
                    n_union_bottom = '0;
                end
                default: begin
                    n_page_has = r_page_has;
                end
            endcase
        end
    end

    // control and extent state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_has     <= 1'b0;
            r_min_x        <= '0;
            r_min_y        <= '0;
            r_max_x        <= '0;
            r_max_y        <= '0;
            r_union_valid  <= 1'b0;
            r_union_left   <= '0;
            r_union_top    <= '0;
            r_union_right  <= '0;
            r_union_bottom <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_page_has     <= n_page_has;
            r_min_x        <= n_min_x;
            r_min_y        <= n_min_y;
            r_max_x        <= n_max_x;
            r_max_y        <= n_max_y;
            r_union_valid  <= n_union_valid;
            r_union_left   <= n_union_left;
            r_union_top    <= n_union_top;
            r_union_right  <= n_union_right;
            r_union_bottom <= n_union_bottom;
            r_out_valid    <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule

// ===== rtl/content_bounding_box_finder.sv =====
// top level of the content bounding box finder: settings, front, queue, back
//
//  channel   direction  handshake                 payload
//  item      in         i_valid / o_stall         i_item   (t_item)
//  result    out        o_valid / i_stall         o_result (t_result)
//  settings  in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One item per clock is taken while the four-entry command queue has room.
// A taken item waits in the queue and the back end executes it from the head;
// a report passes the queue and then the result register before o_valid rises,
// and the back end retires one command a cycle when no report is held back.
// Reset clears the settings to their defaults and empties page and running box.
// A stalled result holds the queue once a report reaches its head; commands ahead
// of that report keep draining, and o_stall rises only when the queue is full.
module content_bounding_box_finder
    import cbbf_pkg::*;
#(
    parameter int unsigned MAX_DIM = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_item       i_item,
    output logic        o_valid,
    input  logic        i_stall,
    output t_result     o_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data
);

    localparam logic [16:0] MaxDim = 17'(MAX_DIM);

    t_cfg r_cfg;
    logic cfg_write;
    logic q_push;
    logic q_pop;
    logic q_empty;
    logic q_full;
    t_cmd q_in;
    t_cmd q_out;

    // window edges are kept clipped to the frame size
    function automatic logic [12:0] clip_dim(input logic [12:0] v);
        logic [12:0] res;
        res = ({4'b0, v} > MaxDim) ? MaxDim[12:0] : v;
        return res;
    endfunction

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    // settings registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.win_left    <= clip_dim(RST_WINDOW_LEFT);
            r_cfg.win_top     <= clip_dim(RST_WINDOW_TOP);
            r_cfg.win_right   <= clip_dim(RST_WINDOW_RIGHT);
            r_cfg.win_bottom  <= clip_dim(RST_WINDOW_BOTTOM);
            r_cfg.alpha_floor <= RST_ALPHA_FLOOR;
            r_cfg.white_level <= RST_WHITE_LEVEL;
            r_cfg.pad         <= RST_PAD_PIXELS;
        end else if (cfg_write) begin
            unique case (i_cfg_index)
                CFG_WINDOW_LEFT:   r_cfg.win_left    <= clip_dim(i_cfg_data);
                CFG_WINDOW_TOP:    r_cfg.win_top     <= clip_dim(i_cfg_data);
                CFG_WINDOW_RIGHT:  r_cfg.win_right   <= clip_dim(i_cfg_data);
                CFG_WINDOW_BOTTOM: r_cfg.win_bottom  <= clip_dim(i_cfg_data);
                CFG_ALPHA_FLOOR:   r_cfg.alpha_floor <= i_cfg_data[7:0];
                CFG_WHITE_LEVEL:   r_cfg.white_level <= i_cfg_data[7:0];
                CFG_PAD_PIXELS:    r_cfg.pad         <= i_cfg_data;
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // classification
    cbbf_front u_front (
        .i_valid (i_valid),
        .i_item  (i_item),
        .i_cfg   (r_cfg),
        .i_full  (q_full),
        .o_stall (o_stall),
        .o_push  (q_push),
        .o_cmd   (q_in)
    );

    // command queue
    cbbf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .i_pop   (q_pop),
        .o_cmd   (q_out),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // execution and result
    cbbf_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_empty  (q_empty),
        .i_cmd    (q_out),
        .o_pop    (q_pop),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result)
    );

endmodule
